### rtl/birm_pkg.sv
// Shared types and constants of the bound instruction pointer register machine.
package birm_pkg;

  typedef enum logic [3:0] {
    OP_ADDI, OP_ADDR, OP_BANI, OP_BANR, OP_BORI, OP_BORR,
    OP_EQIR, OP_EQRI, OP_EQRR, OP_GTIR, OP_GTRI, OP_GTRR,
    OP_MULI, OP_MULR, OP_SETI, OP_SETR
  } op_t;

  localparam logic [1:0] CFG_IP_REG   = 2'd0;
  localparam logic [1:0] CFG_PROG_LEN = 2'd1;
  localparam logic [1:0] CFG_START    = 2'd2;

  typedef struct packed {
    logic               mode;
    op_t                opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [2:0]         dest_index;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] next_address;
    logic signed [63:0] reg_zero;
    logic               halted;
    logic               fault;
  } out_item_t;

  // partial products of the 64-bit wrapping multiply
  typedef struct packed {
    logic [63:0] p_ll;
    logic [31:0] p_lh;
    logic [31:0] p_hl;
  } mul_part_t;

  // register operand capture: override value or memory data
  typedef struct packed {
    logic        ovr;
    logic [63:0] val;
  } rd_fwd_t;

endpackage

### rtl/birm_alu.sv
// Execute-stage ALU: combinational operations and multiply partial products.
module birm_alu (
  input  birm_pkg::op_t       op,
  input  logic [63:0]         va,
  input  logic [63:0]         vb,
  output logic [63:0]         result,
  output birm_pkg::mul_part_t mul_part
);

  always_comb begin
    case (op)
      birm_pkg::OP_ADDI, birm_pkg::OP_ADDR: result = va + vb;
      birm_pkg::OP_BANI, birm_pkg::OP_BANR: result = va & vb;
      birm_pkg::OP_BORI, birm_pkg::OP_BORR: result = va | vb;
      birm_pkg::OP_EQIR, birm_pkg::OP_EQRI, birm_pkg::OP_EQRR:
        result = {63'd0, va == vb};
      birm_pkg::OP_GTIR, birm_pkg::OP_GTRI, birm_pkg::OP_GTRR:
        result = {63'd0, $signed(va) > $signed(vb)};
      birm_pkg::OP_SETI, birm_pkg::OP_SETR: result = va;
      default: result = '0;  // multiply finishes in the next stage
    endcase
  end

  // low 64 bits of a*b = ll + ((lh + hl) << 32)
  assign mul_part.p_ll = va[31:0] * vb[31:0];
  assign mul_part.p_lh = va[31:0] * vb[63:32];
  assign mul_part.p_hl = va[63:32] * vb[31:0];

endmodule

### rtl/bound_ip_register_machine_unit.sv
// Top level of the bound instruction pointer register machine.
//
// Channels: in_valid/in_stall/in_item carries one instruction (or a restart)
// per item; out_valid/out_stall/out_item returns exactly one result per item,
// in order. The cfg_we/cfg_index/cfg_wdata port writes ip_register,
// program_length and start_value; the user must write them only while the
// block is idle, which the block itself does not enforce.
// Throughput: one item per cycle, save for the stalls below. A multiply holds
// the input back while it is in the execute stage, since the 64-bit product is
// summed from three 32x32 partial products in a second stage. A write of
// ip_register stalls the input while the bound register's value is moved
// between the register memory and the instruction pointer flop.
// The registers live in a synchronous memory with a registered read; operands
// are forwarded from the result being committed in the same cycle.
// Reset (synchronous): all registers read as zero, config goes to ip_register
// 0, program_length 1, start_value 0, and nothing is in flight.
// When out_stall is held, the result waits in the output register; one more
// item can be taken into the execute stage, then in_stall rises.
module bound_ip_register_machine_unit #(
  parameter int NUM_REGS    = 6,
  parameter int MAX_PROGRAM = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  birm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output birm_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int LIM_W = $clog2(MAX_PROGRAM + 1);

  function automatic logic [IDX_W-1:0] clamp_bound(input logic [2:0] v);
    logic [IDX_W-1:0] b;
    if (32'(v) < NUM_REGS) b = IDX_W'(v);
    else b = IDX_W'(NUM_REGS - 1);
    return b;
  endfunction

  function automatic birm_pkg::rd_fwd_t fwd_read(
    input logic [IDX_W-1:0] idx,
    input logic [IDX_W-1:0] bnd,
    input logic [63:0]      ip_val,
    input logic             rst_fire,
    input logic [63:0]      start,
    input logic             we,
    input logic [IDX_W-1:0] waddr,
    input logic [63:0]      wdata
  );
    birm_pkg::rd_fwd_t f;
    f.ovr = 1'b1;
    f.val = ip_val;
    if (idx == bnd) begin
      f.val = ip_val;
    end else if (rst_fire) begin
      f.val = (idx == '0) ? start : '0;
    end else if (we && waddr == idx) begin
      f.val = wdata;
    end else begin
      f.ovr = 1'b0;
      f.val = '0;
    end
    return f;
  endfunction

  // configuration
  logic [2:0]  cfg_ip_r;
  logic [8:0]  cfg_len_r;
  logic [63:0] cfg_start_r;

  // register memory, valid bits, instruction pointer and register zero copies
  logic [63:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;
  logic [63:0]         ip_r;
  logic [63:0]         reg0_r;
  logic                swap_pend_r;

  // execute stage
  logic                s1_valid_r;
  logic                s1_restart_r;
  logic                s1_fault_r;
  birm_pkg::op_t       s1_op_r;
  logic [IDX_W-1:0]    s1_dst_r;
  logic                s1_a_reg_r;
  logic                s1_b_reg_r;
  logic [31:0]         s1_imm_a_r;
  logic [31:0]         s1_imm_b_r;
  logic [63:0]         rd_a_mem_r;
  logic [63:0]         rd_b_mem_r;
  logic                rd_a_vld_r;
  logic                rd_b_vld_r;
  birm_pkg::rd_fwd_t   rd_a_fwd_r;
  birm_pkg::rd_fwd_t   rd_b_fwd_r;

  // multiply sum stage
  logic                s2_valid_r;
  logic [IDX_W-1:0]    s2_dst_r;
  birm_pkg::mul_part_t s2_part_r;

  // output register
  logic                out_valid_r;
  birm_pkg::out_item_t out_item_r;

  logic [IDX_W-1:0]    bound;
  logic [LIM_W-1:0]    limit;
  logic                a_reg, b_reg, a_ok, b_ok, dst_ok, fault0;
  logic [IDX_W-1:0]    ra_addr, rb_addr, rd_addr;
  logic                acc, can_acc;
  logic                swap_go;
  logic [IDX_W-1:0]    new_bound;
  logic [63:0]         cur_ip;
  logic [63:0]         va_reg, vb_reg, va, vb;
  logic [63:0]         alu_res;
  birm_pkg::mul_part_t mul_part;
  logic                s1_mul;
  logic [63:0]         s2_res;
  logic                cm_avail, cm_fire, cm_restart, cm_fault, cm_we;
  logic [IDX_W-1:0]    cm_dst, cm_waddr;
  logic [63:0]         cm_res, cm_wdata;
  logic [63:0]         ip_commit, reg0_commit, ip_now;
  logic                halted;
  logic                out_free;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [63:0]         wr_data;
  birm_pkg::rd_fwd_t   fwd_a, fwd_b, fwd_sw;

  always_comb begin
    bound = clamp_bound(cfg_ip_r);
    if (32'(cfg_len_r) < MAX_PROGRAM) limit = LIM_W'(cfg_len_r);
    else limit = LIM_W'(MAX_PROGRAM);
  end

  // decode of the incoming item
  always_comb begin
    a_reg  = !(in_item.opcode == birm_pkg::OP_EQIR || in_item.opcode == birm_pkg::OP_GTIR ||
               in_item.opcode == birm_pkg::OP_SETI);
    b_reg  = in_item.opcode == birm_pkg::OP_ADDR || in_item.opcode == birm_pkg::OP_BANR ||
             in_item.opcode == birm_pkg::OP_BORR || in_item.opcode == birm_pkg::OP_EQIR ||
             in_item.opcode == birm_pkg::OP_EQRR || in_item.opcode == birm_pkg::OP_GTIR ||
             in_item.opcode == birm_pkg::OP_GTRR || in_item.opcode == birm_pkg::OP_MULR;
    a_ok   = $unsigned(in_item.operand_a) < 32'(NUM_REGS);
    b_ok   = $unsigned(in_item.operand_b) < 32'(NUM_REGS);
    dst_ok = 32'(in_item.dest_index) < NUM_REGS;
    fault0 = !in_item.mode && ((a_reg && !a_ok) || (b_reg && !b_ok) || !dst_ok);
    ra_addr = a_ok ? in_item.operand_a[IDX_W-1:0] : '0;
    rb_addr = b_ok ? in_item.operand_b[IDX_W-1:0] : '0;
  end

  // execute operands
  always_comb begin
    va_reg = rd_a_fwd_r.ovr ? rd_a_fwd_r.val : (rd_a_vld_r ? rd_a_mem_r : '0);
    vb_reg = rd_b_fwd_r.ovr ? rd_b_fwd_r.val : (rd_b_vld_r ? rd_b_mem_r : '0);
    va = s1_a_reg_r ? va_reg : {{32{s1_imm_a_r[31]}}, s1_imm_a_r};
    vb = s1_b_reg_r ? vb_reg : {{32{s1_imm_b_r[31]}}, s1_imm_b_r};
  end

  birm_alu u_alu (
    .op       (s1_op_r),
    .va       (va),
    .vb       (vb),
    .result   (alu_res),
    .mul_part (mul_part)
  );

  assign s1_mul = s1_valid_r && !s1_restart_r && !s1_fault_r &&
                  (s1_op_r == birm_pkg::OP_MULI || s1_op_r == birm_pkg::OP_MULR);
  assign s2_res = s2_part_r.p_ll + {s2_part_r.p_lh + s2_part_r.p_hl, 32'd0};

  // commit: the oldest item writes the register state and its result
  always_comb begin
    out_free   = !out_valid_r || !out_stall;
    cm_avail   = s2_valid_r || (s1_valid_r && !s1_mul);
    cm_fire    = cm_avail && out_free;
    cm_restart = !s2_valid_r && s1_restart_r;
    cm_fault   = !s2_valid_r && s1_fault_r;
    cm_dst     = s2_valid_r ? s2_dst_r : s1_dst_r;
    cm_res     = s2_valid_r ? s2_res : alu_res;

    if (cm_restart) ip_commit = (bound == '0) ? cfg_start_r : '0;
    else if (cm_fault) ip_commit = ip_r;
    else if (cm_dst == bound) ip_commit = cm_res + 64'd1;
    else ip_commit = ip_r + 64'd1;

    if (cm_restart) reg0_commit = cfg_start_r;
    else if (cm_fault) reg0_commit = reg0_r;
    else if (bound == '0) reg0_commit = ip_commit;
    else if (cm_dst == '0) reg0_commit = cm_res;
    else reg0_commit = reg0_r;

    halted   = ip_commit[63] || (ip_commit >= 64'(limit));
    cm_we    = cm_fire && (cm_restart || (!cm_fault && cm_dst != bound));
    cm_waddr = cm_restart ? '0 : cm_dst;
    cm_wdata = cm_restart ? cfg_start_r : cm_res;
    ip_now   = cm_fire ? ip_commit : ip_r;
  end

  always_comb begin
    can_acc  = rst_n && !swap_pend_r && !s1_mul && (!s1_valid_r || cm_fire) &&
               (!s2_valid_r || cm_fire);
    in_stall = !can_acc;
    acc      = in_valid && can_acc;
  end

  // moving the bound register: old value to memory, new one fetched
  always_comb begin
    swap_go   = cfg_we && cfg_index == birm_pkg::CFG_IP_REG;
    new_bound = clamp_bound(cfg_wdata[2:0]);
    cur_ip    = swap_pend_r ? va_reg : ip_r;
  end

  always_comb begin
    wr_en   = cm_we || swap_go;
    wr_addr = cm_we ? cm_waddr : bound;
    wr_data = cm_we ? cm_wdata : cur_ip;
    rd_addr = swap_go ? new_bound : ra_addr;
    fwd_a   = fwd_read(ra_addr, bound, ip_now, cm_fire && cm_restart, cfg_start_r,
                       cm_we, cm_waddr, cm_wdata);
    fwd_b   = fwd_read(rb_addr, bound, ip_now, cm_fire && cm_restart, cfg_start_r,
                       cm_we, cm_waddr, cm_wdata);
    fwd_sw.ovr = (new_bound == bound);
    fwd_sw.val = cur_ip;
  end

  // register memory
  always_ff @(posedge clk) begin
    if (wr_en) rf_mem[wr_addr] <= wr_data;
    if (acc || swap_go) rd_a_mem_r <= rf_mem[rd_addr];
    if (acc) rd_b_mem_r <= rf_mem[rb_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ip_r    <= '0;
      cfg_len_r   <= 9'd1;
      cfg_start_r <= '0;
      rf_vld_r    <= '0;
      ip_r        <= '0;
      reg0_r      <= '0;
      swap_pend_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          birm_pkg::CFG_IP_REG:   cfg_ip_r    <= cfg_wdata[2:0];
          birm_pkg::CFG_PROG_LEN: cfg_len_r   <= cfg_wdata[8:0];
          birm_pkg::CFG_START:    cfg_start_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (cm_fire && cm_restart) rf_vld_r <= NUM_REGS'(1);
      else if (wr_en) rf_vld_r[wr_addr] <= 1'b1;

      if (cm_fire) ip_r <= ip_commit;
      else if (swap_pend_r && !swap_go) ip_r <= va_reg;
      if (cm_fire) reg0_r <= reg0_commit;
      swap_pend_r <= swap_go;

      if (acc) s1_valid_r <= 1'b1;
      else if (cm_fire || s1_mul) s1_valid_r <= 1'b0;

      if (s1_mul) s2_valid_r <= 1'b1;
      else if (cm_fire) s2_valid_r <= 1'b0;

      if (cm_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_restart_r <= in_item.mode;
      s1_fault_r   <= fault0;
      s1_op_r      <= in_item.opcode;
      s1_dst_r     <= IDX_W'(in_item.dest_index);
      s1_a_reg_r   <= a_reg;
      s1_b_reg_r   <= b_reg;
      s1_imm_a_r   <= in_item.operand_a;
      s1_imm_b_r   <= in_item.operand_b;
      rd_a_vld_r   <= rf_vld_r[ra_addr];
      rd_b_vld_r   <= rf_vld_r[rb_addr];
      rd_a_fwd_r   <= fwd_a;
      rd_b_fwd_r   <= fwd_b;
    end else if (swap_go) begin
      rd_a_vld_r <= rf_vld_r[new_bound];
      rd_a_fwd_r <= fwd_sw;
    end
    if (s1_mul) begin
      s2_dst_r  <= s1_dst_r;
      s2_part_r <= mul_part;
    end
    if (cm_fire) begin
      out_item_r.next_address <= ip_commit;
      out_item_r.reg_zero     <= reg0_commit;
      out_item_r.halted       <= halted;
      out_item_r.fault        <= cm_fault;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/birm_checker.sv
// Port-level checks for the register machine, bound to the top level.
module birm_checker #(
  parameter int MAX_PROGRAM = 256
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input birm_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  a_neg_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.next_address[63] |-> out_item.halted)
    else $error("negative next address without halt");

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.halted |->
      $unsigned(out_item.next_address) < 64'(MAX_PROGRAM))
    else $error("running with next address beyond program");

endmodule

bind bound_ip_register_machine_unit birm_checker #(
  .MAX_PROGRAM (MAX_PROGRAM)
) u_birm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
